// ----- rtl/core/nmea_pkg.sv -----
// Shared widths, operation codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package nmea_pkg;

  localparam int ValW   = 16;  // Q3.12 sample width
  localparam int ErrW   = 32;  // Q16.16 error width
  localparam int SumW   = 37;  // sum of values
  localparam int SqW    = 51;  // sum of squares
  localparam int CrossW = 52;  // sum of cross products
  localparam int DiffW  = 53;  // sum of squared differences
  localparam int TotW   = 48;  // running total of best errors
  localparam int WideW  = 74;  // covariance and variance terms
  localparam int MaW    = 37;  // serial multiplier: scanned operand
  localparam int MbW    = 52;  // serial multiplier: shifted operand
  localparam int MpW    = 89;  // serial multiplier: product
  localparam int RootW  = 36;  // square root result
  localparam int RadW   = 72;  // square root radicand
  localparam int SremW  = 38;  // square root remainder
  localparam int NumW   = 88;  // divider numerator and quotient
  localparam int DenW   = 74;  // divider denominator
  localparam int IterW  = 7;   // iteration counter
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLAMP_LO = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLAMP_HI = 2'd2;

  typedef logic [3:0] op_t;

  localparam op_t OP_RM_DIV   = 4'd0;
  localparam op_t OP_RM_SQRT  = 4'd1;
  localparam op_t OP_MUL_NSGR = 4'd2;
  localparam op_t OP_MUL_SGSR = 4'd3;
  localparam op_t OP_MUL_NSGG = 4'd4;
  localparam op_t OP_MUL_SGSG = 4'd5;
  localparam op_t OP_MUL_NSRR = 4'd6;
  localparam op_t OP_MUL_SRSR = 4'd7;
  localparam op_t OP_SQRT_VG  = 4'd8;
  localparam op_t OP_SQRT_VR  = 4'd9;
  localparam op_t OP_MUL_DEN  = 4'd10;
  localparam op_t OP_DIV_CC   = 4'd11;
  localparam op_t OP_DIV_AVG  = 4'd12;

  typedef struct packed {
    logic load;   // capture the input item
    logic acc;    // fold the captured item into the pair sums
    logic start;  // launch op on the serial units
    op_t  op;
    logic best;   // merge pair error into the best, clear pair sums
    logic tally;  // close the tensor
    logic emit;   // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_el;
    logic last_smp;
    logic last_ten;
    logic mode;
    logic done;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/nmea_ctrl.sv -----
// Sequencing state machine for item intake, error computation and result output.
`timescale 1ns / 1ps
`default_nettype none
module nmea_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire nmea_pkg::dp_sts_t sts_i,
  output nmea_pkg::dp_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_BEST  = 3'd4;
  localparam logic [2:0] ST_TALLY = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]      state_q, state_d;
  nmea_pkg::op_t   op_q, op_d;

  function automatic nmea_pkg::op_t next_op(input nmea_pkg::op_t op);
    nmea_pkg::op_t nxt;
    case (op)
      nmea_pkg::OP_RM_DIV:   nxt = nmea_pkg::OP_RM_SQRT;
      nmea_pkg::OP_MUL_NSGR: nxt = nmea_pkg::OP_MUL_SGSR;
      nmea_pkg::OP_MUL_SGSR: nxt = nmea_pkg::OP_MUL_NSGG;
      nmea_pkg::OP_MUL_NSGG: nxt = nmea_pkg::OP_MUL_SGSG;
      nmea_pkg::OP_MUL_SGSG: nxt = nmea_pkg::OP_MUL_NSRR;
      nmea_pkg::OP_MUL_NSRR: nxt = nmea_pkg::OP_MUL_SRSR;
      nmea_pkg::OP_MUL_SRSR: nxt = nmea_pkg::OP_SQRT_VG;
      nmea_pkg::OP_SQRT_VG:  nxt = nmea_pkg::OP_SQRT_VR;
      nmea_pkg::OP_SQRT_VR:  nxt = nmea_pkg::OP_MUL_DEN;
      nmea_pkg::OP_MUL_DEN:  nxt = nmea_pkg::OP_DIV_CC;
      default:               nxt = nmea_pkg::OP_RM_DIV;
    endcase
    return nxt;
  endfunction

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (!sts_i.last_el) begin
          state_d = ST_IDLE;
        end else begin
          op_d    = sts_i.mode ? nmea_pkg::OP_MUL_NSGR : nmea_pkg::OP_RM_DIV;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          if (op_q == nmea_pkg::OP_RM_SQRT || op_q == nmea_pkg::OP_DIV_CC) begin
            state_d = ST_BEST;
          end else if (op_q == nmea_pkg::OP_DIV_AVG) begin
            state_d = ST_EMIT;
          end else begin
            op_d    = next_op(op_q);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_BEST: begin
        cmd_o.best = 1'b1;
        state_d    = sts_i.last_smp ? ST_TALLY : ST_IDLE;
      end
      ST_TALLY: begin
        cmd_o.tally = 1'b1;
        if (sts_i.last_ten) begin
          op_d    = nmea_pkg::OP_DIV_AVG;
          state_d = ST_ISSUE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register frees up
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= nmea_pkg::OP_RM_DIV;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/nmea_dp.sv -----
// Datapath: configuration, pair sums, serial multiply/root/divide units, result register.
`timescale 1ns / 1ps
`default_nettype none
module nmea_dp #(
  parameter int MAX_ELEMENTS = 1048576,
  parameter int MAX_TENSORS  = 65536
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [nmea_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [nmea_pkg::ValW-1:0]          cfg_data_i,
  input  wire logic signed [nmea_pkg::ValW-1:0]   gen_value_i,
  input  wire logic signed [nmea_pkg::ValW-1:0]   ref_value_i,
  input  wire logic                               last_element_i,
  input  wire logic                               last_sample_i,
  input  wire logic                               last_tensor_i,
  input  wire nmea_pkg::dp_cmd_t                  cmd_i,
  output nmea_pkg::dp_sts_t                       sts_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [nmea_pkg::ErrW-1:0]        best_error_o,
  output logic signed [nmea_pkg::ErrW-1:0]        average_error_o,
  output logic                                    final_res_o
);

  localparam int CntW = $clog2(MAX_ELEMENTS + 1);
  localparam int TcW  = $clog2(MAX_TENSORS + 1);

  localparam logic [1:0] UNIT_MUL  = 2'd0;
  localparam logic [1:0] UNIT_SQRT = 2'd1;
  localparam logic [1:0] UNIT_DIV  = 2'd2;

  function automatic logic [1:0] unit_of(input nmea_pkg::op_t op);
    logic [1:0] u;
    case (op)
      nmea_pkg::OP_RM_DIV, nmea_pkg::OP_DIV_CC, nmea_pkg::OP_DIV_AVG: u = UNIT_DIV;
      nmea_pkg::OP_RM_SQRT, nmea_pkg::OP_SQRT_VG, nmea_pkg::OP_SQRT_VR: u = UNIT_SQRT;
      default: u = UNIT_MUL;
    endcase
    return u;
  endfunction

  // configuration
  logic                              mode_q;
  logic signed [nmea_pkg::ValW-1:0]  clamp_lo_q, clamp_hi_q;

  // captured item
  logic signed [nmea_pkg::ValW-1:0]  g_q, r_q;
  logic [31:0]                       pgg_q, prr_q, pgr_q, pdd_q;
  logic                              last_el_q, last_smp_q, last_ten_q;

  // pair sums and tensor state
  logic [CntW-1:0]                   cnt_q;
  logic signed [nmea_pkg::SumW-1:0]  sum_gen_q, sum_ref_q;
  logic [nmea_pkg::SqW-1:0]          sum_gen_sq_q, sum_ref_sq_q;
  logic signed [nmea_pkg::CrossW-1:0] sum_cross_q;
  logic [nmea_pkg::DiffW-1:0]        sum_diff_q;
  logic signed [nmea_pkg::ErrW-1:0]  best_q;
  logic                              have_best_q;
  logic signed [nmea_pkg::TotW-1:0]  total_q;
  logic [TcW-1:0]                    tcnt_q;

  // intermediate results
  logic signed [nmea_pkg::WideW-1:0] cov_q, vg_q, vr_q, den_q;
  logic [nmea_pkg::RootW-1:0]        sgrt_q, srrt_q;
  logic [63:0]                       rmq_q;
  logic signed [nmea_pkg::ErrW-1:0]  err_q, res_q, avg_q;

  // serial unit control
  logic                              run_q, done_q;
  logic [nmea_pkg::IterW-1:0]        iter_q;
  nmea_pkg::op_t                     op_q;

  logic [nmea_pkg::MaW-1:0]          ma_q;
  logic [nmea_pkg::MpW-1:0]          mb_q, mp_q;
  logic                              mneg_q;
  logic [nmea_pkg::RadW-1:0]         rad_q;
  logic [nmea_pkg::RootW-1:0]        root_q;
  logic [nmea_pkg::SremW-1:0]        srem_q;
  logic [nmea_pkg::NumW-1:0]         dnum_q, dquo_q;
  logic [nmea_pkg::DenW-1:0]         drem_q, dden_q;

  // intake arithmetic
  logic signed [nmea_pkg::ValW-1:0]  lo_cl, gen_cl;
  logic signed [16:0]                diff_c;
  logic signed [31:0]                pgg_c, prr_c, pgr_c;
  logic signed [33:0]                pdd_c;

  assign lo_cl  = (gen_value_i < clamp_lo_q) ? clamp_lo_q : gen_value_i;
  assign gen_cl = (lo_cl > clamp_hi_q) ? clamp_hi_q : lo_cl;
  assign diff_c = $signed({gen_cl[15], gen_cl}) - $signed({ref_value_i[15], ref_value_i});
  assign pgg_c  = gen_cl * gen_cl;
  assign prr_c  = ref_value_i * ref_value_i;
  assign pgr_c  = gen_cl * ref_value_i;
  assign pdd_c  = diff_c * diff_c;

  // operand magnitudes
  logic [nmea_pkg::SumW-1:0]   mag_sg, mag_sr;
  logic [nmea_pkg::CrossW-1:0] mag_sgr;
  logic [nmea_pkg::WideW-1:0]  mag_cov;
  logic [nmea_pkg::TotW-1:0]   mag_tot;
  logic [nmea_pkg::MaW-1:0]    cnt_ma;

  assign mag_sg  = sum_gen_q[nmea_pkg::SumW-1] ? -sum_gen_q : sum_gen_q;
  assign mag_sr  = sum_ref_q[nmea_pkg::SumW-1] ? -sum_ref_q : sum_ref_q;
  assign mag_sgr = sum_cross_q[nmea_pkg::CrossW-1] ? -sum_cross_q : sum_cross_q;
  assign mag_cov = cov_q[nmea_pkg::WideW-1] ? -cov_q : cov_q;
  assign mag_tot = total_q[nmea_pkg::TotW-1] ? -total_q : total_q;
  assign cnt_ma  = {{(nmea_pkg::MaW-CntW){1'b0}}, cnt_q};

  // operand selection at launch
  logic [nmea_pkg::MaW-1:0]  mul_a;
  logic [nmea_pkg::MbW-1:0]  mul_b;
  logic                      mul_neg;
  logic [nmea_pkg::RadW-1:0] rad_c;
  logic [nmea_pkg::NumW-1:0] num_c;
  logic [nmea_pkg::DenW-1:0] den_c;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    rad_c   = '0;
    num_c   = '0;
    den_c   = '0;
    case (cmd_i.op)
      nmea_pkg::OP_MUL_NSGR: begin
        mul_a   = cnt_ma;
        mul_b   = mag_sgr;
        mul_neg = sum_cross_q[nmea_pkg::CrossW-1];
      end
      nmea_pkg::OP_MUL_SGSR: begin
        mul_a   = mag_sg;
        mul_b   = {{(nmea_pkg::MbW-nmea_pkg::SumW){1'b0}}, mag_sr};
        mul_neg = sum_gen_q[nmea_pkg::SumW-1] ^ sum_ref_q[nmea_pkg::SumW-1];
      end
      nmea_pkg::OP_MUL_NSGG: begin
        mul_a = cnt_ma;
        mul_b = {{(nmea_pkg::MbW-nmea_pkg::SqW){1'b0}}, sum_gen_sq_q};
      end
      nmea_pkg::OP_MUL_SGSG: begin
        mul_a = mag_sg;
        mul_b = {{(nmea_pkg::MbW-nmea_pkg::SumW){1'b0}}, mag_sg};
      end
      nmea_pkg::OP_MUL_NSRR: begin
        mul_a = cnt_ma;
        mul_b = {{(nmea_pkg::MbW-nmea_pkg::SqW){1'b0}}, sum_ref_sq_q};
      end
      nmea_pkg::OP_MUL_SRSR: begin
        mul_a = mag_sr;
        mul_b = {{(nmea_pkg::MbW-nmea_pkg::SumW){1'b0}}, mag_sr};
      end
      nmea_pkg::OP_MUL_DEN: begin
        mul_a = {{(nmea_pkg::MaW-nmea_pkg::RootW){1'b0}}, sgrt_q};
        mul_b = {{(nmea_pkg::MbW-nmea_pkg::RootW){1'b0}}, srrt_q};
      end
      nmea_pkg::OP_SQRT_VG: rad_c = vg_q[nmea_pkg::WideW-1] ? '0 : vg_q[nmea_pkg::RadW-1:0];
      nmea_pkg::OP_SQRT_VR: rad_c = vr_q[nmea_pkg::WideW-1] ? '0 : vr_q[nmea_pkg::RadW-1:0];
      nmea_pkg::OP_RM_SQRT: rad_c = {{(nmea_pkg::RadW-64){1'b0}}, rmq_q};
      nmea_pkg::OP_RM_DIV: begin
        num_c = {{(nmea_pkg::NumW-nmea_pkg::DiffW-8){1'b0}}, sum_diff_q, 8'h00};
        den_c = {{(nmea_pkg::DenW-CntW){1'b0}}, cnt_q};
      end
      nmea_pkg::OP_DIV_CC: begin
        num_c = {mag_cov[nmea_pkg::NumW-17:0], 16'h0000};
        den_c = den_q;
      end
      nmea_pkg::OP_DIV_AVG: begin
        num_c = {{(nmea_pkg::NumW-nmea_pkg::TotW){1'b0}}, mag_tot};
        den_c = {{(nmea_pkg::DenW-TcW){1'b0}}, tcnt_q};
      end
      default: ;
    endcase
  end

  // unit step logic
  logic [nmea_pkg::MpW-1:0]     mp_neg;
  logic signed [nmea_pkg::WideW-1:0] mres;
  logic [nmea_pkg::SremW+1:0]   srem_n, strial, sdiff;
  logic [nmea_pkg::DenW:0]      drem_n, ddiff;
  logic                         dge;
  logic [16:0]                  cc_mag;
  logic [nmea_pkg::ErrW-1:0]    cc_ext, avg_mag;

  assign mp_neg  = -mp_q;
  assign mres    = mneg_q ? mp_neg[nmea_pkg::WideW-1:0] : mp_q[nmea_pkg::WideW-1:0];
  assign srem_n  = {srem_q, rad_q[nmea_pkg::RadW-1 -: 2]};
  assign strial  = {2'b00, root_q, 2'b01};
  assign sdiff   = srem_n - strial;
  assign drem_n  = {drem_q, dnum_q[nmea_pkg::NumW-1]};
  assign ddiff   = drem_n - {1'b0, dden_q};
  assign dge     = drem_n >= {1'b0, dden_q};
  assign cc_mag  = (dquo_q > nmea_pkg::NumW'(65536)) ? 17'd65536 : dquo_q[16:0];
  assign cc_ext  = {{(nmea_pkg::ErrW-17){1'b0}}, cc_mag};
  assign avg_mag = dquo_q[nmea_pkg::ErrW-1:0];

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      clamp_lo_q   <= '0;
      clamp_hi_q   <= 16'sd4096;
      cnt_q        <= '0;
      sum_gen_q    <= '0;
      sum_ref_q    <= '0;
      sum_gen_sq_q <= '0;
      sum_ref_sq_q <= '0;
      sum_cross_q  <= '0;
      sum_diff_q   <= '0;
      best_q       <= '0;
      have_best_q  <= 1'b0;
      total_q      <= '0;
      tcnt_q       <= '0;
      run_q        <= 1'b0;
      done_q       <= 1'b0;
      iter_q       <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          nmea_pkg::CFG_MODE:     mode_q     <= cfg_data_i[0];
          nmea_pkg::CFG_CLAMP_LO: clamp_lo_q <= cfg_data_i;
          nmea_pkg::CFG_CLAMP_HI: clamp_hi_q <= cfg_data_i;
          default: ;
        endcase
      end

      // saturate the pair: extra elements only carry their marks
      if (cmd_i.acc && cnt_q < CntW'(MAX_ELEMENTS)) begin
        cnt_q        <= cnt_q + 1'b1;
        sum_gen_q    <= sum_gen_q + {{(nmea_pkg::SumW-16){g_q[15]}}, g_q};
        sum_ref_q    <= sum_ref_q + {{(nmea_pkg::SumW-16){r_q[15]}}, r_q};
        sum_gen_sq_q <= sum_gen_sq_q + {{(nmea_pkg::SqW-32){1'b0}}, pgg_q};
        sum_ref_sq_q <= sum_ref_sq_q + {{(nmea_pkg::SqW-32){1'b0}}, prr_q};
        sum_cross_q  <= sum_cross_q + {{(nmea_pkg::CrossW-32){pgr_q[31]}}, pgr_q};
        sum_diff_q   <= sum_diff_q + {{(nmea_pkg::DiffW-32){1'b0}}, pdd_q};
      end

      if (cmd_i.best) begin
        if (!have_best_q || (mode_q ? (err_q > best_q) : (err_q < best_q))) begin
          best_q      <= err_q;
          have_best_q <= 1'b1;
        end
        cnt_q        <= '0;
        sum_gen_q    <= '0;
        sum_ref_q    <= '0;
        sum_gen_sq_q <= '0;
        sum_ref_sq_q <= '0;
        sum_cross_q  <= '0;
        sum_diff_q   <= '0;
      end

      if (cmd_i.tally) begin
        best_q      <= '0;
        have_best_q <= 1'b0;
        if (tcnt_q < TcW'(MAX_TENSORS)) begin
          total_q <= total_q + {{(nmea_pkg::TotW-nmea_pkg::ErrW){best_q[31]}}, best_q};
          tcnt_q  <= tcnt_q + 1'b1;
        end
      end

      if (cmd_i.emit && last_ten_q) begin
        total_q <= '0;
        tcnt_q  <= '0;
      end

      done_q <= !cmd_i.start && run_q && (iter_q == nmea_pkg::IterW'(1));
      if (cmd_i.start) begin
        run_q <= 1'b1;
        case (unit_of(cmd_i.op))
          UNIT_MUL:  iter_q <= nmea_pkg::IterW'(nmea_pkg::MaW);
          UNIT_SQRT: iter_q <= nmea_pkg::IterW'(nmea_pkg::RootW);
          default:   iter_q <= nmea_pkg::IterW'(nmea_pkg::NumW);
        endcase
      end else if (run_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == nmea_pkg::IterW'(1)) begin
          run_q <= 1'b0;
        end
      end

      if (cmd_i.emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      g_q        <= gen_cl;
      r_q        <= ref_value_i;
      pgg_q      <= pgg_c;
      prr_q      <= prr_c;
      pgr_q      <= pgr_c;
      pdd_q      <= pdd_c[31:0];
      last_el_q  <= last_element_i;
      last_smp_q <= last_sample_i;
      last_ten_q <= last_tensor_i;
    end

    if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      ma_q   <= mul_a;
      mb_q   <= {{(nmea_pkg::MpW-nmea_pkg::MbW){1'b0}}, mul_b};
      mp_q   <= '0;
      mneg_q <= mul_neg;
      rad_q  <= rad_c;
      root_q <= '0;
      srem_q <= '0;
      dnum_q <= num_c;
      dden_q <= den_c;
      drem_q <= '0;
      dquo_q <= '0;
    end else if (run_q) begin
      case (unit_of(op_q))
        UNIT_MUL: begin
          if (ma_q[0]) begin
            mp_q <= mp_q + mb_q;
          end
          mb_q <= {mb_q[nmea_pkg::MpW-2:0], 1'b0};
          ma_q <= {1'b0, ma_q[nmea_pkg::MaW-1:1]};
        end
        UNIT_SQRT: begin
          if (srem_n >= strial) begin
            srem_q <= sdiff[nmea_pkg::SremW-1:0];
            root_q <= {root_q[nmea_pkg::RootW-2:0], 1'b1};
          end else begin
            srem_q <= srem_n[nmea_pkg::SremW-1:0];
            root_q <= {root_q[nmea_pkg::RootW-2:0], 1'b0};
          end
          rad_q <= {rad_q[nmea_pkg::RadW-3:0], 2'b00};
        end
        default: begin
          drem_q <= dge ? ddiff[nmea_pkg::DenW-1:0] : drem_n[nmea_pkg::DenW-1:0];
          dquo_q <= {dquo_q[nmea_pkg::NumW-2:0], dge};
          dnum_q <= {dnum_q[nmea_pkg::NumW-2:0], 1'b0};
        end
      endcase
    end

    // write back the finished op
    if (done_q) begin
      case (op_q)
        nmea_pkg::OP_MUL_NSGR: cov_q <= mres;
        nmea_pkg::OP_MUL_SGSR: cov_q <= cov_q - mres;
        nmea_pkg::OP_MUL_NSGG: vg_q  <= mres;
        nmea_pkg::OP_MUL_SGSG: vg_q  <= vg_q - mres;
        nmea_pkg::OP_MUL_NSRR: vr_q  <= mres;
        nmea_pkg::OP_MUL_SRSR: vr_q  <= vr_q - mres;
        nmea_pkg::OP_MUL_DEN:  den_q <= mres;
        nmea_pkg::OP_SQRT_VG:  sgrt_q <= root_q;
        nmea_pkg::OP_SQRT_VR:  srrt_q <= root_q;
        nmea_pkg::OP_RM_DIV:   rmq_q <= dquo_q[63:0];
        nmea_pkg::OP_RM_SQRT:  err_q <= root_q[nmea_pkg::ErrW-1:0];
        nmea_pkg::OP_DIV_CC: begin
          // zero variance scores zero
          if (den_q == '0) begin
            err_q <= '0;
          end else begin
            err_q <= cov_q[nmea_pkg::WideW-1] ? -cc_ext : cc_ext;
          end
        end
        nmea_pkg::OP_DIV_AVG:  avg_q <= total_q[nmea_pkg::TotW-1] ? -avg_mag : avg_mag;
        default: ;
      endcase
    end

    if (cmd_i.tally) begin
      res_q <= best_q;
    end

    if (cmd_i.emit) begin
      best_error_o    <= res_q;
      average_error_o <= last_ten_q ? avg_q : '0;
      final_res_o     <= last_ten_q;
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.last_el  = last_el_q;
    sts_o.last_smp = last_smp_q;
    sts_o.last_ten = last_ten_q;
    sts_o.mode     = mode_q;
    sts_o.done     = done_q;
    sts_o.out_busy = out_valid_o && out_stall_i;
  end

endmodule
`default_nettype wire

// ----- rtl/core/nearest_match_error_average_core.sv -----
// Top level: nearest-match error scoring of generated tensors against reference samples.
// Element pairs enter one at a time; each is captured with clamp and the four products,
// then accumulated. At the last element of a pair the error is formed on shared serial
// units (a multiplier, a square root and a divider): RMSE mode uses one divide and one
// root, correlation mode seven products, two roots and one divide. Closing a tensor adds
// the tally and the output load; closing the set adds a divide for the average. Input
// stalls during all of this and while a finished result waits for a full output register
// to drain.
`timescale 1ns / 1ps
`default_nettype none
module nearest_match_error_average_core #(
  parameter int MAX_ELEMENTS = 1048576,
  parameter int MAX_TENSORS  = 65536
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [nmea_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [nmea_pkg::ValW-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [nmea_pkg::ValW-1:0]  gen_value_i,
  input  wire logic signed [nmea_pkg::ValW-1:0]  ref_value_i,
  input  wire logic                              last_element_i,
  input  wire logic                              last_sample_i,
  input  wire logic                              last_tensor_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [nmea_pkg::ErrW-1:0]       best_error_o,
  output logic signed [nmea_pkg::ErrW-1:0]       average_error_o,
  output logic                                   final_res_o
);

  nmea_pkg::dp_cmd_t cmd;
  nmea_pkg::dp_sts_t sts;

  nmea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nmea_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_TENSORS  (MAX_TENSORS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .gen_value_i     (gen_value_i),
    .ref_value_i     (ref_value_i),
    .last_element_i  (last_element_i),
    .last_sample_i   (last_sample_i),
    .last_tensor_i   (last_tensor_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .best_error_o    (best_error_o),
    .average_error_o (average_error_o),
    .final_res_o     (final_res_o)
  );

endmodule
`default_nettype wire

// ----- sim/nmea_tb_pkg.sv -----
// Shared scoring-mode codes for the match-error testbench.
`timescale 1ns / 1ps
package nmea_tb_pkg;

  typedef enum logic {
    MODE_RMSE = 1'b0,
    MODE_CORR = 1'b1
  } score_mode_e;

endpackage

// ----- sim/nmea_checker.sv -----
// Checker: predicts best and average match errors and compares them with the core outputs.
`timescale 1ns / 1ps
module nmea_checker
  import nmea_pkg::*;
  import nmea_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [ValW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic signed [ValW-1:0] gen_value_i,
  input  logic signed [ValW-1:0] ref_value_i,
  input  logic                   last_element_i,
  input  logic                   last_sample_i,
  input  logic                   last_tensor_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [ErrW-1:0] best_error_i,
  input  logic signed [ErrW-1:0] average_error_i,
  input  logic                   final_res_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int MaxElements = 1048576;
  localparam int MaxTensors  = 65536;

  typedef struct {
    logic signed [ErrW-1:0] best;
    logic signed [ErrW-1:0] average;
    logic                   fin;
  } score_t;

  score_t score_q[$];

  score_mode_e            mode;
  logic signed [ValW-1:0] clamp_lo, clamp_hi;

  longint unsigned element_count;
  longint          sum_gen, sum_ref, sum_cross;
  longint unsigned sum_gen_sq, sum_ref_sq, sum_diff_sq;
  logic signed [ErrW-1:0] best_so_far;
  logic            have_best;
  longint          error_total;
  longint unsigned tensor_count;

  initial fail_count_o = 0;
  assign pending_o = score_q.size();

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [127:0] root, trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root[63:0];
  endfunction

  function automatic logic signed [ErrW-1:0] pair_rmse();
    logic [63:0] n, mean_sq;
    n = (element_count != 0) ? element_count : 64'd1;
    mean_sq = (sum_diff_sq << 8) / n;
    return ErrW'(isqrt({64'd0, mean_sq}));
  endfunction

  function automatic logic signed [ErrW-1:0] pair_corr();
    logic signed [127:0] n, sg, sr, sgr, sgg, srr, cov, var_g, var_r;
    logic [127:0] den, num, quot;
    logic         neg;
    n   = {64'd0, element_count};
    sg  = sum_gen;
    sr  = sum_ref;
    sgr = sum_cross;
    sgg = {64'd0, sum_gen_sq};
    srr = {64'd0, sum_ref_sq};
    cov   = n * sgr - sg * sr;
    var_g = n * sgg - sg * sg;
    var_r = n * srr - sr * sr;
    if (var_g < 0) var_g = '0;
    if (var_r < 0) var_r = '0;
    den = {64'd0, isqrt(var_g)} * {64'd0, isqrt(var_r)};
    if (den == 0) return '0;
    neg = cov < 0;
    num = neg ? -cov : cov;
    quot = (num << 16) / den;
    if (quot > 128'd65536) quot = 128'd65536;
    return neg ? -$signed(quot[ErrW-1:0]) : $signed(quot[ErrW-1:0]);
  endfunction

  task automatic clear_pair();
    element_count = 0;
    sum_gen = 0;
    sum_ref = 0;
    sum_cross = 0;
    sum_gen_sq = 0;
    sum_ref_sq = 0;
    sum_diff_sq = 0;
  endtask

  task automatic score_item();
    longint g, r, d;
    logic signed [ErrW-1:0] err;
    score_t s;
    g = gen_value_i;
    r = ref_value_i;
    // clamp: raise to low first, then cut at high, so crossed bounds give high
    if (g < clamp_lo) g = clamp_lo;
    if (g > clamp_hi) g = clamp_hi;
    if (element_count < MaxElements) begin
      d = g - r;
      element_count++;
      sum_gen += g;
      sum_ref += r;
      sum_gen_sq += g * g;
      sum_ref_sq += r * r;
      sum_cross += g * r;
      sum_diff_sq += d * d;
    end
    if (!last_element_i) return;
    err = (mode == MODE_CORR) ? pair_corr() : pair_rmse();
    clear_pair();
    if (!have_best || ((mode == MODE_CORR) ? err > best_so_far : err < best_so_far)) begin
      best_so_far = err;
      have_best = 1'b1;
    end
    if (!last_sample_i) return;
    s.best = best_so_far;
    s.average = '0;
    s.fin = 1'b0;
    best_so_far = '0;
    have_best = 1'b0;
    if (tensor_count < MaxTensors) begin
      error_total += longint'(s.best);
      tensor_count++;
    end
    if (last_tensor_i) begin
      s.fin = 1'b1;
      s.average = (tensor_count != 0) ? ErrW'(error_total / longint'(tensor_count)) : '0;
      error_total = 0;
      tensor_count = 0;
    end
    score_q.push_back(s);
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    score_t want;
    if (!rst_ni) begin
      mode <= MODE_RMSE;
      clamp_lo <= 16'sd0;
      clamp_hi <= 16'sd4096;
      clear_pair();
      best_so_far = '0;
      have_best = 1'b0;
      error_total = 0;
      tensor_count = 0;
      score_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:     mode <= score_mode_e'(cfg_data_i[0]);
          CFG_CLAMP_LO: clamp_lo <= cfg_data_i;
          CFG_CLAMP_HI: clamp_hi <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) score_item();
      if (out_valid_i && !out_stall_i) begin
        if (score_q.size() == 0) begin
          report($sformatf("unexpected result best=%0d", best_error_i));
        end else begin
          want = score_q.pop_front();
          if (best_error_i !== want.best)
            report($sformatf("best_error %0d, want %0d", best_error_i, want.best));
          if (average_error_i !== want.average)
            report($sformatf("average_error %0d, want %0d", average_error_i, want.average));
          if (final_res_i !== want.fin)
            report($sformatf("final_res %0b, want %0b", final_res_i, want.fin));
        end
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives element pairs and register writes into the core and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import nmea_pkg::*;
  import nmea_tb_pkg::*;

  localparam int     RandItems = 1400;
  localparam int     Drain     = 700;      // longest no-result pair plus the average divide
  localparam longint CycleLimit = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_MODE;
  logic [ValW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ValW-1:0] gen_value = '0;
  logic signed [ValW-1:0] ref_value = '0;
  logic last_element = 1'b0, last_sample = 1'b0, last_tensor = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ErrW-1:0] best_error, average_error;
  logic final_res;
  int fail_count, pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int sent = 0;
  longint cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nearest_match_error_average_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .gen_value_i(gen_value), .ref_value_i(ref_value),
    .last_element_i(last_element), .last_sample_i(last_sample),
    .last_tensor_i(last_tensor),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .best_error_o(best_error), .average_error_o(average_error),
    .final_res_o(final_res)
  );

  nmea_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .gen_value_i(gen_value), .ref_value_i(ref_value),
    .last_element_i(last_element), .last_sample_i(last_sample),
    .last_tensor_i(last_tensor),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .best_error_i(best_error), .average_error_i(average_error),
    .final_res_i(final_res),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one item; return at the edge that takes it
  task automatic offer(input logic signed [ValW-1:0] g, input logic signed [ValW-1:0] r,
                       input logic le, input logic ls, input logic lt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    gen_value <= g;
    ref_value <= r;
    last_element <= le;
    last_sample <= ls;
    last_tensor <= lt;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    sent++;
  endtask

  // drop valid and wait until the core is idle
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  // hold the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic configure(input score_mode_e m, input logic [ValW-1:0] lo,
                           input logic [ValW-1:0] hi);
    settle();
    write_reg(CFG_MODE, ValW'(m));
    write_reg(CFG_CLAMP_LO, lo);
    write_reg(CFG_CLAMP_HI, hi);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    offer(16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1'b0);
    offer(16'sh8000, 16'sh7fff, 1'b1, 1'b1, 1'b0);
    offer(16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b0);
    offer(16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b0);
    // stray marks without last element
    offer(16'sh0100, 16'sh0200, 1'b0, 1'b1, 1'b1);
    offer(16'sh0300, 16'sh0400, 1'b0, 1'b0, 1'b1);
    // last tensor without last sample
    offer(16'sh0500, 16'sh0600, 1'b1, 1'b0, 1'b1);
    // flat pair: zero variance
    offer(16'sh0800, 16'sh0800, 1'b0, 1'b0, 1'b0);
    offer(16'sh0800, 16'sh0800, 1'b1, 1'b1, 1'b0);
    // rising pair: positive correlation
    offer(16'sh0100, 16'sh0100, 1'b0, 1'b0, 1'b0);
    offer(16'sh0200, 16'sh0300, 1'b0, 1'b0, 1'b0);
    offer(16'sh0300, 16'sh0500, 1'b1, 1'b0, 1'b0);
    // falling pair: negative correlation
    offer(16'sh0100, 16'sh0500, 1'b0, 1'b0, 1'b0);
    offer(16'sh0200, 16'sh0300, 1'b0, 1'b0, 1'b0);
    offer(16'sh0300, 16'sh0100, 1'b1, 1'b1, 1'b0);
    offer(16'shffff, 16'sh0000, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic random_value_pair(input int style, input int base, output logic [15:0] g,
                                   output logic [15:0] r);
    case (style)
      0: begin
        g = 16'($urandom);
        r = 16'($urandom);
      end
      1: begin
        g = 16'(base + $urandom_range(0, 600) - 300);
        r = 16'(base + $urandom_range(0, 600) - 300);
      end
      2: begin
        g = 16'(base + $urandom_range(0, 8000) - 4000);
        r = 16'(g + $urandom_range(0, 200) - 100);
      end
      default: begin
        g = 16'(base);
        r = 16'(base + 77);
      end
    endcase
  endtask

  task automatic run_random(input int count);
    int stop, n_ten, n_smp, n_el, style, base;
    logic [15:0] g, r;
    logic le, ls, lt;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(9) == 0) begin
        random_value_pair(0, 0, g, r);
        offer(g, r, $urandom_range(3) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      n_ten = $urandom_range(1, 3);
      for (int t = 0; t < n_ten; t++) begin
        n_smp = $urandom_range(1, 3);
        for (int s = 0; s < n_smp; s++) begin
          n_el = ($urandom_range(7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
          style = $urandom_range(3);
          base = $urandom_range(0, 9000) - 1000;
          for (int e = 0; e < n_el; e++) begin
            random_value_pair(style, base, g, r);
            le = (e == n_el - 1);
            ls = le ? (s == n_smp - 1) : ($urandom_range(7) == 0);
            lt = (le && ls) ? (t == n_ten - 1) : ($urandom_range(7) == 0);
            offer(g, r, le, ls, lt);
          end
        end
      end
    end
  endtask

  initial begin
    int idle_send[4] = '{0, 54, 0, 34};
    int idle_recv[4] = '{0, 0, 54, 34};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    configure(MODE_CORR, 16'h0000, 16'h1000);
    run_directed();

    configure(MODE_CORR, 16'h8000, 16'h7fff);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_send[ph];
      recv_stall_pct = idle_recv[ph];
      run_random(RandItems / 16);
    end
    // hold the receiver off so the core backs up its input
    hold_req = 1'b1;
    run_random(RandItems / 16);
    settle();

    configure(MODE_RMSE, 16'h8000, 16'h7fff);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_send[ph];
      recv_stall_pct = idle_recv[ph];
      run_random(RandItems / 16);
    end

    // crossed bounds
    configure(MODE_CORR, 16'h0400, 16'hfc00);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    run_random(RandItems / 8);
    configure(MODE_RMSE, 16'h7fff, 16'h8000);
    run_random(RandItems / 8);

    configure(MODE_RMSE, 16'($urandom_range(0, 2000) - 2000), 16'($urandom_range(0, 6000)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(RandItems / 8);
    configure(MODE_CORR, 16'($urandom_range(0, 3000) - 3000), 16'($urandom_range(0, 5000)));
    send_idle_pct = 54;
    recv_stall_pct = 54;
    run_random(RandItems / 8);

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/nmea_pkg.sv
rtl/core/nmea_ctrl.sv
rtl/core/nmea_dp.sv
rtl/core/nearest_match_error_average_core.sv
sim/nmea_tb_pkg.sv
sim/nmea_checker.sv
sim/tb_top.sv
